// File: src/rowo_pkg.sv
// Shared types and constants for the write-once overlay byte store.
package rowo_pkg;

  // Store geometry
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

  // Beat field widths
  localparam int MODE_W    = 2;
  localparam int IN_ADDR_W = 16;
  localparam int DATA_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int MAP_W     = 17;
  localparam int CNT_W     = 32;

  localparam logic [MAP_W-1:0] MAP_MAX = MAP_W'(65536);

  typedef enum logic [MODE_W-1:0] {
    MODE_TEMPLATE = 2'd0,
    MODE_PAD      = 2'd1,
    MODE_OVERLAY  = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_TEMPLATE = 3'd0,
    STAT_PADDED   = 3'd1,
    STAT_WRITTEN  = 3'd2,
    STAT_SAME     = 3'd3,
    STAT_CONFLICT = 3'd4,
    STAT_READ     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_PAD,
    S_PAD_END
  } state_t;

  // Memory port requests from the sequencer
  typedef struct packed {
    logic              mark_we;
    logic [ADDR_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic [ADDR_W-1:0] mark_raddr;
    logic              byte_we;
    logic [ADDR_W-1:0] byte_waddr;
    logic [DATA_W-1:0] byte_wdata;
    logic [ADDR_W-1:0] byte_raddr;
  } mem_req_t;

  // Finished item from the sequencer
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [DATA_W-1:0] data;
    logic              map_inc;
    logic              conf_inc;
  } res_t;

endpackage

// File: src/rowo_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module rowo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/rowo_ctrl.sv
// Sequencer: mark clearing, template append, padding walk, overlay and read.
module rowo_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rowo_pkg::MODE_W-1:0]   mode,
  input  logic [rowo_pkg::IN_ADDR_W-1:0] address,
  input  logic [rowo_pkg::DATA_W-1:0]   data_in,
  output logic                          busy,
  input  logic                          mark_rdata,
  input  logic [rowo_pkg::DATA_W-1:0]   byte_rdata,
  output rowo_pkg::mem_req_t            mem,
  output rowo_pkg::res_t                res
);
  import rowo_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [LEN_W-1:0]  FULL_LEN  = LEN_W'(STORE_DEPTH);
  localparam logic [IN_ADDR_W:0] ADDR_LIM = (IN_ADDR_W + 1)'(STORE_DEPTH);

  state_t state, state_next;

  // Latched beat
  mode_t                op_mode;
  logic [IN_ADDR_W-1:0] op_addr;
  logic [DATA_W-1:0]    op_data;

  // Template length and pad walk
  logic [LEN_W-1:0]  tmpl_len, tmpl_len_next;
  logic [LEN_W-1:0]  pad_idx;
  logic [ADDR_W-1:0] pad_ptr;
  logic [ADDR_W-1:0] pad_wr;
  logic              pad_pend;
  logic              pad_issue;
  logic [ADDR_W-1:0] clr_idx;

  logic accept;
  logic op_oor;
  logic tmpl_room;

  assign accept    = start && (state == S_IDLE);
  assign op_oor    = {1'b0, op_addr} >= ADDR_LIM;
  assign tmpl_room = tmpl_len < FULL_LEN;
  assign pad_issue = (state == S_PAD) && (pad_idx < FULL_LEN);
  assign busy      = (state != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tmpl_len <= '0;
      clr_idx  <= '0;
      pad_pend <= 1'b0;
    end else begin
      tmpl_len <= tmpl_len_next;
      pad_pend <= pad_issue;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Beat capture and pad pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= mode_t'(mode);
      op_addr <= address;
      op_data <= data_in;
      pad_idx <= tmpl_len;
      pad_ptr <= '0;
    end else if (pad_issue) begin
      pad_idx <= pad_idx + 1'b1;
      if (tmpl_len != '0) begin
        // wrap the template pointer at the template length
        if (LEN_W'(pad_ptr) + 1'b1 == tmpl_len) begin
          pad_ptr <= '0;
        end else begin
          pad_ptr <= pad_ptr + 1'b1;
        end
      end
    end
    pad_wr <= pad_idx[ADDR_W-1:0];
  end

  // Next state, memory requests and results
  always_comb begin
    state_next     = state;
    tmpl_len_next  = tmpl_len;
    mem            = '0;
    res            = '0;
    res.status     = STAT_TEMPLATE;
    unique case (state)
      S_CLEAR: begin
        mem.mark_we    = 1'b1;
        mem.mark_waddr = clr_idx;
        mem.mark_wdata = 1'b0;
        if (clr_idx == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (mode_t'(mode) == MODE_TEMPLATE) begin
          mem.mark_raddr = tmpl_len[ADDR_W-1:0];
          mem.byte_raddr = tmpl_len[ADDR_W-1:0];
        end else begin
          mem.mark_raddr = address[ADDR_W-1:0];
          mem.byte_raddr = address[ADDR_W-1:0];
        end
        if (start) begin
          state_next = (mode_t'(mode) == MODE_PAD) ? S_PAD : S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_IDLE;
        res.valid  = 1'b1;
        unique case (op_mode)
          MODE_TEMPLATE: begin
            res.status = STAT_TEMPLATE;
            if (tmpl_room) begin
              tmpl_len_next  = tmpl_len + 1'b1;
              mem.byte_we    = !mark_rdata;
              mem.byte_waddr = tmpl_len[ADDR_W-1:0];
              mem.byte_wdata = op_data;
            end
          end
          MODE_OVERLAY: begin
            priority if (op_oor) begin
              res.status = STAT_CONFLICT;
            end else if (!mark_rdata) begin
              res.status     = STAT_WRITTEN;
              res.map_inc    = 1'b1;
              mem.byte_we    = 1'b1;
              mem.byte_waddr = op_addr[ADDR_W-1:0];
              mem.byte_wdata = op_data;
              mem.mark_we    = 1'b1;
              mem.mark_waddr = op_addr[ADDR_W-1:0];
              mem.mark_wdata = 1'b1;
            end else if (byte_rdata == op_data) begin
              res.status = STAT_SAME;
            end else begin
              res.status   = STAT_CONFLICT;
              res.conf_inc = 1'b1;
            end
          end
          MODE_READ: begin
            res.status = STAT_READ;
            res.data   = op_oor ? '0 : byte_rdata;
          end
          MODE_PAD: begin
            res.status = STAT_PADDED;
          end
        endcase
      end
      S_PAD: begin
        // read mark of the target and template byte, write in the following cycle
        mem.mark_raddr = pad_idx[ADDR_W-1:0];
        mem.byte_raddr = pad_ptr;
        mem.byte_we    = pad_pend && !mark_rdata;
        mem.byte_waddr = pad_wr;
        mem.byte_wdata = (tmpl_len == '0) ? '0 : byte_rdata;
        if (!pad_issue) begin
          state_next = S_PAD_END;
        end
      end
      S_PAD_END: begin
        state_next    = S_IDLE;
        tmpl_len_next = FULL_LEN;
        res.valid     = 1'b1;
        res.status    = STAT_PADDED;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    tmpl_len <= FULL_LEN)
    else $error("template length past store depth");

  a_pad_no_template_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD && mem.byte_we) |-> (LEN_W'(mem.byte_waddr) >= tmpl_len))
    else $error("pad write lands inside the template");

  a_clear_no_byte_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !mem.byte_we)
    else $error("byte write during mark clearing");

  a_pad_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && mode_t'(mode) == MODE_PAD) |=> (state == S_PAD))
    else $error("pad beat did not start the walk");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> !res.valid)
    else $error("back to back results from one beat");
`endif

endmodule

// File: src/rom_overlay_write_once.sv
// Top level: write-once overlay byte store built from a template.
//
// A beat is taken when start is high and busy is low. Template, overlay and
// read beats are accepted, then do the lookup and write-back once the mark
// and byte memories have returned their registered reads; the result
// appears on the result ports, marked by done, in the cycle after that and
// for that one cycle only, so the receiver must take it. A pad beat walks the
// store one entry a cycle: it keeps busy high until the walk has reached the
// last entry of the store, and done is raised as busy falls. After reset
// busy stays high while the mark memory is cleared.
module rom_overlay_write_once (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rowo_pkg::MODE_W-1:0]   mode,
  input  logic [rowo_pkg::IN_ADDR_W-1:0] address,
  input  logic [rowo_pkg::DATA_W-1:0]   data_in,
  output logic                          done,
  output logic [rowo_pkg::STATUS_W-1:0] status,
  output logic [rowo_pkg::DATA_W-1:0]   data_out,
  output logic [rowo_pkg::MAP_W-1:0]    mapped_count,
  output logic [rowo_pkg::CNT_W-1:0]    conflict_count
);
  import rowo_pkg::*;

  mem_req_t          mem;
  res_t              res;
  logic              mark_rdata;
  logic [DATA_W-1:0] byte_rdata;
  logic [MAP_W-1:0]  mapped_total;
  logic [CNT_W-1:0]  conflict_total;

  rowo_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .address    (address),
    .data_in    (data_in),
    .busy       (busy),
    .mark_rdata (mark_rdata),
    .byte_rdata (byte_rdata),
    .mem        (mem),
    .res        (res)
  );

  // Write-once marks
  rowo_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mem.mark_we),
    .waddr (mem.mark_waddr),
    .wdata (mem.mark_wdata),
    .raddr (mem.mark_raddr),
    .rdata (mark_rdata)
  );

  // Byte store
  rowo_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_byte_ram (
    .clk   (clk),
    .we    (mem.byte_we),
    .waddr (mem.byte_waddr),
    .wdata (mem.byte_wdata),
    .raddr (mem.byte_raddr),
    .rdata (byte_rdata)
  );

  // Running totals, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      mapped_total   <= '0;
      conflict_total <= '0;
    end else if (res.valid) begin
      if (res.map_inc && mapped_total != MAP_MAX) begin
        mapped_total <= mapped_total + 1'b1;
      end
      if (res.conf_inc && conflict_total != '1) begin
        conflict_total <= conflict_total + 1'b1;
      end
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status   <= res.status;
      data_out <= res.data;
    end
  end

  assign mapped_count   = mapped_total;
  assign conflict_count = conflict_total;

`ifndef SYNTHESIS
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> done)
    else $error("result beat not presented");

  a_map_step: assert property (@(posedge clk) disable iff (rst)
    !res.valid |=> $stable(mapped_total) && $stable(conflict_total))
    else $error("totals moved without a result");

  a_map_bound: assert property (@(posedge clk) disable iff (rst)
    mapped_total <= MAP_MAX)
    else $error("mapped total past store size");
`endif

endmodule
